/* hdl/pws_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pws_pkg
// Shared constants, field layout and inter-module types of the wavetable synth.
// ----------------------------------------------------------------------------
package pws_pkg;

	localparam int VOICE_COUNT   = 24;
	localparam int TABLE_LENGTH  = 256;
	localparam int FRACTION_BITS = 16;

	localparam int VOICE_AW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int CNT_W    = $clog2(VOICE_COUNT + 1);
	localparam int TAB_AW   = $clog2(TABLE_LENGTH);
	localparam int PHASE_W  = TAB_AW + FRACTION_BITS;

	// field widths
	localparam int OPC_W  = 2;
	localparam int BEND_W = 12;
	localparam int VOL_W  = 12;
	localparam int VIDX_W = 5;
	localparam int STEP_W = 24;
	localparam int TIDX_W = 8;
	localparam int TVAL_W = 16;
	localparam int DAC_W  = 12;

	// input word layout, lowest bit first
	localparam int BEND_LO = 0;
	localparam int VOL_LO  = BEND_LO + BEND_W;
	localparam int VIDX_LO = VOL_LO + VOL_W;
	localparam int KEY_LO  = VIDX_LO + VIDX_W;
	localparam int STEP_LO = KEY_LO + 1;
	localparam int TIDX_LO = STEP_LO + STEP_W;
	localparam int TVAL_LO = TIDX_LO + TIDX_W;
	localparam int IN_BITS = TVAL_LO + TVAL_W;
	localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((DAC_W + 7) / 8) * 8;

	// opcodes
	localparam logic [OPC_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OPC_W-1:0] OP_VOICE = 2'd1;
	localparam logic [OPC_W-1:0] OP_TABLE = 2'd2;

	// arithmetic
	localparam int BEND_SHIFT     = 10;
	localparam int PROD_W         = STEP_W + BEND_W;
	localparam int SUM_W          = TVAL_W + $clog2(VOICE_COUNT);
	localparam int SUM_SHIFT      = 7;
	localparam int QSUM_W         = SUM_W - SUM_SHIFT;
	localparam int MAG_W          = VOL_W + QSUM_W;
	localparam int VOLUME_DIVISOR = 4095;
	localparam int RECIP_SHIFT    = MAG_W + 11;
	localparam int RECIP_W        = MAG_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(VOLUME_DIVISOR));
	localparam int QUO_W          = MAG_W - VOL_W + 1;
	localparam int SMP_W          = QUO_W + 2;
	localparam int DAC_MID        = 2048;
	localparam int DAC_MAX        = 4095;

	typedef struct packed {
		logic                held;
		logic [STEP_W-1:0]   step;
		logic [PHASE_W-1:0]  phase;
	} voice_t;

	typedef struct packed {
		logic                go;
		logic [OPC_W-1:0]    opcode;
		logic [BEND_W-1:0]   bend;
		logic [VIDX_W-1:0]   vidx;
		logic                key;
		logic [STEP_W-1:0]   step;
		logic [TIDX_W-1:0]   tidx;
		logic [TVAL_W-1:0]   tval;
	} walk_req_t;

	typedef struct packed {
		logic                done;
		logic [SUM_W-1:0]    sum;
	} walk_rsp_t;

	typedef struct packed {
		logic                go;
		logic [SUM_W-1:0]    sum;
		logic [VOL_W-1:0]    volume;
	} mix_req_t;

	typedef struct packed {
		logic                done;
		logic [DAC_W-1:0]    dac;
		logic                clip;
	} mix_rsp_t;

endpackage
`default_nettype wire

/* hdl/pws_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pws_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* hdl/pws_walk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pws_walk
// Voice and wavetable memories; set-voice and table writes, and the voice walk
// that advances each held voice and sums its table samples.
// ----------------------------------------------------------------------------
module pws_walk (
	input  logic               clk,
	input  logic               arst_n,
	input  pws_pkg::walk_req_t req,
	output pws_pkg::walk_rsp_t rsp
);
	import pws_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETRD = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;

	logic [1:0]              st_q;
	logic [VOICE_COUNT-1:0]  valid_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    done_q;
	logic [BEND_W-1:0]       bend_q;
	logic                    key_q;
	logic [STEP_W-1:0]       step_q;
	logic [VOICE_AW-1:0]     vidx_q;
	logic signed [SUM_W-1:0] sum_q;

	logic                    rd_s1;
	logic [VOICE_AW-1:0]     vi_s1;
	logic                    act_s2;
	logic [VOICE_AW-1:0]     vi_s2;
	logic [PHASE_W-1:0]      ph_s2;
	logic [STEP_W-1:0]       step_s2;
	logic [PROD_W-1:0]       prod_s2;
	logic                    act_s3;

	logic                    v_we;
	logic [VOICE_AW-1:0]     v_waddr;
	logic [VOICE_AW-1:0]     v_raddr;
	logic [VOICE_AW-1:0]     v_sel;
	voice_t                  v_wdata;
	logic [$bits(voice_t)-1:0] v_rdata;
	voice_t                  v_entry;
	logic                    w_we;
	logic [TAB_AW-1:0]       w_waddr;
	logic [TAB_AW-1:0]       w_raddr;
	logic [TVAL_W-1:0]       w_rdata;
	logic [PHASE_W-1:0]      ph_new;
	logic                    vidx_ok;
	logic                    tidx_ok;
	logic                    idle_go;

	pws_ram #(.WIDTH($bits(voice_t)), .DEPTH(VOICE_COUNT)) u_voice_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	pws_ram #(.WIDTH(TVAL_W), .DEPTH(TABLE_LENGTH)) u_wave_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (req.tval),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	always_comb begin
		idle_go = req.go && (st_q == ST_IDLE);
		vidx_ok = {1'b0, req.vidx} < (VIDX_W + 1)'(VOICE_COUNT);
		tidx_ok = {1'b0, req.tidx} < (TIDX_W + 1)'(TABLE_LENGTH);

		// unwritten voices read as reset
		v_sel   = (st_q == ST_SETRD) ? vidx_q : vi_s1;
		v_entry = valid_q[v_sel] ? voice_t'(v_rdata) : '0;
		v_raddr = (st_q == ST_IDLE) ? VOICE_AW'(req.vidx) : cnt_q[VOICE_AW-1:0];

		// wrap is implicit: modulus is 2^PHASE_W
		ph_new  = ph_s2 + PHASE_W'(step_s2) + prod_s2[BEND_SHIFT +: PHASE_W];

		v_we    = act_s2 || (st_q == ST_SETRD);
		v_waddr = act_s2 ? vi_s2 : vidx_q;
		if (act_s2) begin
			v_wdata = '{held: 1'b1, step: step_s2, phase: ph_new};
		end else begin
			v_wdata = '{held: key_q, step: step_q, phase: v_entry.phase};
		end

		w_we    = idle_go && (req.opcode == OP_TABLE) && tidx_ok;
		w_waddr = TAB_AW'(req.tidx);
		w_raddr = ph_new[PHASE_W-1 -: TAB_AW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			valid_q <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			rd_s1   <= 1'b0;
			act_s2  <= 1'b0;
			act_s3  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			rd_s1  <= 1'b0;
			act_s2 <= rd_s1 && v_entry.held;
			act_s3 <= act_s2;
			unique case (st_q)
				ST_IDLE: begin
					if (req.go) begin
						unique case (req.opcode)
							OP_TICK: begin
								st_q  <= ST_WALK;
								cnt_q <= '0;
							end
							OP_VOICE: begin
								if (vidx_ok) begin
									st_q <= ST_SETRD;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SETRD: begin
					valid_q[vidx_q] <= 1'b1;
					done_q          <= 1'b1;
					st_q            <= ST_IDLE;
				end
				ST_WALK: begin
					if (cnt_q != CNT_W'(VOICE_COUNT)) begin
						rd_s1 <= 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end else if (!rd_s1 && !act_s2 && !act_s3) begin
						done_q <= 1'b1;
						st_q   <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (idle_go) begin
			bend_q <= req.bend;
			key_q  <= req.key;
			step_q <= req.step;
			vidx_q <= VOICE_AW'(req.vidx);
		end
		if (idle_go && (req.opcode == OP_TICK)) begin
			sum_q <= '0;
		end else if (act_s3) begin
			sum_q <= sum_q + SUM_W'($signed(w_rdata));
		end
		vi_s1   <= cnt_q[VOICE_AW-1:0];
		vi_s2   <= vi_s1;
		ph_s2   <= v_entry.phase;
		step_s2 <= v_entry.step;
		prod_s2 <= v_entry.step * bend_q;
	end

	assign rsp.done = done_q;
	assign rsp.sum  = sum_q;

endmodule
`default_nettype wire

/* hdl/pws_mix.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pws_mix
// Output scaling: sum / 128, times volume / 4095 (both toward zero),
// offset to mid-scale and clipped to the DAC range.
// ----------------------------------------------------------------------------
module pws_mix (
	input  logic              clk,
	input  logic              arst_n,
	input  pws_pkg::mix_req_t req,
	output pws_pkg::mix_rsp_t rsp
);
	import pws_pkg::*;

	localparam logic signed [SMP_W-1:0] SMP_MID = SMP_W'(DAC_MID);
	localparam logic signed [SMP_W-1:0] SMP_MAX = SMP_W'(DAC_MAX);

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                     neg_s1, neg_s2, neg_s3, neg_s4;
	logic [QSUM_W-1:0]        qs_s1;
	logic [VOL_W-1:0]         vol_s1;
	logic [MAG_W-1:0]         m_s2, m_s3;
	logic [QUO_W-1:0]         q0_s3, q_s4;
	logic [DAC_W-1:0]         dac_s5;
	logic                     clip_s5;

	logic [SUM_W-1:0]         sum_mag;
	logic [MAG_W+RECIP_W-1:0] recip_prod;
	logic [MAG_W-1:0]         rem;
	logic signed [SMP_W-1:0]  smp;

	always_comb begin
		sum_mag    = req.sum[SUM_W-1] ? SUM_W'(-req.sum) : req.sum;
		recip_prod = m_s2 * RECIP;
		rem        = m_s3 - MAG_W'(q0_s3) * MAG_W'(VOLUME_DIVISOR);
		smp        = neg_s4 ? (SMP_MID - SMP_W'(q_s4)) : (SMP_MID + SMP_W'(q_s4));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= req.go;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		// magnitudes throughout, sign restored at the offset
		neg_s1 <= req.sum[SUM_W-1];
		qs_s1  <= sum_mag[SUM_W-1:SUM_SHIFT];
		vol_s1 <= req.volume;

		neg_s2 <= neg_s1;
		m_s2   <= vol_s1 * qs_s1;

		neg_s3 <= neg_s2;
		m_s3   <= m_s2;
		q0_s3  <= recip_prod[RECIP_SHIFT +: QUO_W];

		// reciprocal estimate is exact or one low
		neg_s4 <= neg_s3;
		q_s4   <= (rem >= MAG_W'(VOLUME_DIVISOR)) ? q0_s3 + 1'b1 : q0_s3;

		if (smp > SMP_MAX) begin
			dac_s5  <= DAC_W'(DAC_MAX);
			clip_s5 <= 1'b1;
		end else if (smp < 0) begin
			dac_s5  <= '0;
			clip_s5 <= 1'b1;
		end else begin
			dac_s5  <= smp[DAC_W-1:0];
			clip_s5 <= 1'b0;
		end
	end

	assign rsp.done = v_s5;
	assign rsp.dac  = dac_s5;
	assign rsp.clip = clip_s5;

endmodule
`default_nettype wire

/* hdl/polyphonic_wavetable_synth_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// polyphonic_wavetable_synth_unit
// Tick: the 24-voice walk over the voice RAM (one voice per cycle, plus
// pipeline drain), then a 5-stage mix and the output register.
// Set voice: read-modify-write of the voice entry. Table write: written
// as the word is accepted. One word in flight at a time; a finished output
// word may wait while the next input word is taken. Reset clears control
// state and all voices.
// ----------------------------------------------------------------------------
module polyphonic_wavetable_synth_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// bend_level, volume_level, voice_index, key_down, phase_step,
	// table_index, table_value
	input  logic [pws_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// opcode
	input  logic [pws_pkg::OPC_W-1:0]        s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// dac_value
	output logic [pws_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// clipped
	output logic                             m_axis_tuser
);
	import pws_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_MIX  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]        st_q;
	logic [OPC_W-1:0]  op_q;
	logic [VOL_W-1:0]  vol_q;
	logic              out_vld_q;
	logic [DAC_W-1:0]  dac_q;
	logic              clip_q;
	logic [DAC_W-1:0]  mix_dac_q;
	logic              mix_clip_q;

	logic              accept;
	logic              out_free;
	walk_req_t         walk_req;
	walk_rsp_t         walk_rsp;
	mix_req_t          mix_req;
	mix_rsp_t          mix_rsp;

	assign s_axis_tready = (st_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;

	always_comb begin
		walk_req.go     = accept;
		walk_req.opcode = s_axis_tuser;
		walk_req.bend   = s_axis_tdata[BEND_LO +: BEND_W];
		walk_req.vidx   = s_axis_tdata[VIDX_LO +: VIDX_W];
		walk_req.key    = s_axis_tdata[KEY_LO];
		walk_req.step   = s_axis_tdata[STEP_LO +: STEP_W];
		walk_req.tidx   = s_axis_tdata[TIDX_LO +: TIDX_W];
		walk_req.tval   = s_axis_tdata[TVAL_LO +: TVAL_W];

		mix_req.go      = walk_rsp.done && (op_q == OP_TICK) && (st_q == ST_WALK);
		mix_req.sum     = walk_rsp.sum;
		mix_req.volume  = vol_q;
	end

	pws_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (walk_req),
		.rsp    (walk_rsp)
	);

	pws_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mix_req),
		.rsp    (mix_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			if ((st_q == ST_OUT) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (walk_rsp.done) begin
						st_q <= (op_q == OP_TICK) ? ST_MIX : ST_IDLE;
					end
				end
				ST_MIX: begin
					if (mix_rsp.done) begin
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_axis_tuser;
			vol_q <= s_axis_tdata[VOL_LO +: VOL_W];
		end
		if (mix_rsp.done) begin
			mix_dac_q  <= mix_rsp.dac;
			mix_clip_q <= mix_rsp.clip;
		end
		if ((st_q == ST_OUT) && out_free) begin
			dac_q  <= mix_dac_q;
			clip_q <= mix_clip_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {(OUT_DATA_W - DAC_W)'(0), dac_q};
	assign m_axis_tuser  = clip_q;

endmodule
`default_nettype wire
